// ----- hw/rtl/psc_pkg.sv -----
// Package for the palindromic substring counter.
// Shared sizes, request payload types and the cell control struct.
// No dependencies.
package psc_pkg;

  localparam int MAX_LEN   = 64;
  localparam int CHAR_W    = 8;
  localparam int CNT_W     = 12;
  localparam int LEN_W     = $clog2(MAX_LEN + 1);
  localparam int GRP       = 8;
  localparam int NGRP      = (MAX_LEN + GRP - 1) / GRP;
  localparam int GRP_W     = $clog2(GRP + 1);
  localparam int PC_W      = $clog2(MAX_LEN + 1);
  localparam int TOTAL_MAX = (1 << CNT_W) - 1;

  typedef struct packed {
    logic [CHAR_W-1:0] char_in;
    logic              is_last;
  } in_req_t;

  typedef struct packed {
    logic [CNT_W-1:0] pal_count;
    logic             done_res;
    logic             overflow;
  } out_req_t;

  // Per-cell controls for one column update.
  typedef struct packed {
    logic wr;      // this cell takes the new character
    logic active;  // cell index is within the string, update its flag
    logic near;    // span of one or two characters, no inner check
    logic clr;     // string finished, drop the flag
  } cell_ctl_t;

endpackage

// ----- hw/rtl/palindromic_substring_counter.sv -----
// Palindromic substring counter top level: cell chain, flag counter and sequencer.
// Uses psc_pkg, psc_cell and psc_popcount.
//
// Each request carries one character; the result carries the running count of
// palindromic substrings of the string so far. A taken request goes through the
// column update in the cell row (one cell per stored character, MAX_LEN cells),
// the registered group count of the flags, and the add into the total. One item
// is in flight at a time: no new request is accepted until the current one has
// finished, and it cannot finish while an earlier result is held by out_stall.
// A finished result sits in an output register and the next request is accepted while it waits.
// Characters past MAX_LEN are dropped and raise overflow. After the request
// marked last, all state clears for the next string.
module palindromic_substring_counter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  psc_pkg::in_req_t   in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output psc_pkg::out_req_t  out_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_UPD  = 2'd1;
  localparam logic [1:0] S_CNT  = 2'd2;
  localparam logic [1:0] S_SUM  = 2'd3;

  logic [1:0]                  state_r, state_nxt;
  logic [psc_pkg::CHAR_W-1:0]  char_r, char_nxt;
  logic                        last_r, last_nxt;
  logic [psc_pkg::LEN_W-1:0]   len_r, len_nxt;
  logic [psc_pkg::CNT_W-1:0]   total_r, total_nxt;
  logic                        ovf_r, ovf_nxt;
  logic                        out_valid_r, out_valid_nxt;
  psc_pkg::out_req_t           out_r, out_nxt;

  logic                        upd_en;
  logic                        clr;
  logic                        finish;
  logic [psc_pkg::MAX_LEN-1:0] flags;
  logic [psc_pkg::PC_W-1:0]    added;
  logic [psc_pkg::PC_W-1:0]    added_eff;
  logic [psc_pkg::CNT_W:0]     sum_wide;
  logic [psc_pkg::CNT_W-1:0]   sum_sat;

  assign upd_en = (state_r == S_UPD) && (len_r < psc_pkg::LEN_W'(psc_pkg::MAX_LEN));
  assign finish = (state_r == S_SUM) && (!out_valid_r || !out_stall);
  assign clr    = finish && last_r;

  // Cell row: cell i looks at cell i+1's flag from the previous column.
  for (genvar i = 0; i < psc_pkg::MAX_LEN; i++) begin : g_cell
    psc_pkg::cell_ctl_t ctl;
    logic               nbr;

    assign ctl.wr     = upd_en && (len_r == psc_pkg::LEN_W'(i));
    assign ctl.active = upd_en && (psc_pkg::LEN_W'(i) <= len_r);
    assign ctl.near   = (len_r == psc_pkg::LEN_W'(i)) || (len_r == psc_pkg::LEN_W'(i + 1));
    assign ctl.clr    = clr;

    if (i == psc_pkg::MAX_LEN - 1) begin : g_end
      assign nbr = 1'b0;
    end else begin : g_mid
      assign nbr = flags[i + 1];
    end

    psc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .char_new (char_r),
      .nbr_flag (nbr),
      .flag     (flags[i])
    );
  end

  psc_popcount u_popcount (
    .clk   (clk),
    .flags (flags),
    .count (added)
  );

  // A dropped character leaves the old column in place; it adds nothing.
  assign added_eff = ovf_r ? '0 : added;

  assign sum_wide = {1'b0, total_r} + (psc_pkg::CNT_W + 1)'(added_eff);
  assign sum_sat  = (sum_wide > (psc_pkg::CNT_W + 1)'(psc_pkg::TOTAL_MAX))
                  ? psc_pkg::CNT_W'(psc_pkg::TOTAL_MAX) : sum_wide[psc_pkg::CNT_W-1:0];

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    char_nxt      = char_r;
    last_nxt      = last_r;
    len_nxt       = len_r;
    total_nxt     = total_r;
    ovf_nxt       = ovf_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          char_nxt  = in_data.char_in;
          last_nxt  = in_data.is_last;
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        if (upd_en) begin
          len_nxt = len_r + 1'b1;
        end else begin
          ovf_nxt = 1'b1;
        end
        state_nxt = S_CNT;
      end
      S_CNT: begin
        state_nxt = S_SUM;
      end
      S_SUM: begin
        if (finish) begin
          out_nxt.pal_count = sum_sat;
          out_nxt.done_res  = last_r;
          out_nxt.overflow  = ovf_r;
          out_valid_nxt     = 1'b1;
          total_nxt         = sum_sat;
          if (last_r) begin
            len_nxt   = '0;
            total_nxt = '0;
            ovf_nxt   = 1'b0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      total_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      total_r     <= total_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r <= char_nxt;
    last_r <= last_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- hw/rtl/psc_cell.sv -----
// One cell of the compare chain: stores one character and one palindrome-end flag.
// Reads its right neighbor's flag from the previous column. Uses psc_pkg.
module psc_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  psc_pkg::cell_ctl_t          ctl,
  input  logic [psc_pkg::CHAR_W-1:0]  char_new,
  input  logic                        nbr_flag,
  output logic                        flag
);

  logic [psc_pkg::CHAR_W-1:0] char_r;
  logic                       flag_r;
  logic                       flag_nxt;
  logic                       match;

  // The cell being written compares the character with itself.
  assign match = ctl.wr || (char_r == char_new);

  always_comb begin
    flag_nxt = flag_r;
    if (ctl.clr) begin
      flag_nxt = 1'b0;
    end else if (ctl.active) begin
      flag_nxt = match && (ctl.near || nbr_flag);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      char_r <= char_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r <= 1'b0;
    end else begin
      flag_r <= flag_nxt;
    end
  end

  assign flag = flag_r;

endmodule

// ----- hw/rtl/psc_popcount.sv -----
// Counts the set flags of the column: registered group counts, then a short sum.
// Uses psc_pkg.
module psc_popcount (
  input  logic                         clk,
  input  logic [psc_pkg::MAX_LEN-1:0]  flags,
  output logic [psc_pkg::PC_W-1:0]     count
);

  logic [psc_pkg::GRP_W-1:0] grp_r   [psc_pkg::NGRP];
  logic [psc_pkg::GRP_W-1:0] grp_nxt [psc_pkg::NGRP];

  always_comb begin
    for (int g = 0; g < psc_pkg::NGRP; g++) begin
      grp_nxt[g] = '0;
      for (int b = 0; b < psc_pkg::GRP; b++) begin
        if (g * psc_pkg::GRP + b < psc_pkg::MAX_LEN) begin
          grp_nxt[g] = grp_nxt[g]
                     + psc_pkg::GRP_W'(flags[g * psc_pkg::GRP + b]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < psc_pkg::NGRP; g++) begin
      grp_r[g] <= grp_nxt[g];
    end
  end

  always_comb begin
    count = '0;
    for (int g = 0; g < psc_pkg::NGRP; g++) begin
      count = count + psc_pkg::PC_W'(grp_r[g]);
    end
  end

endmodule

// ----- test/tb_top.sv -----
// Testbench for palindromic_substring_counter: streams byte strings and checks every
// running count against a built-in predictor, under several idle and stall mixes.
// Depends on psc_pkg and the palindromic_substring_counter RTL.
module tb_top;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  psc_pkg::in_req_t  in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  psc_pkg::out_req_t out_data;

  // Predictor state: characters of the current string and the latest column of
  // palindrome-end flags (bit i set when the substring starting at i is one).
  logic [psc_pkg::CHAR_W-1:0]  seen_chars [psc_pkg::MAX_LEN];
  logic [psc_pkg::MAX_LEN-1:0] end_flags = '0;
  int unsigned                 stored_len = 0;
  int unsigned                 pal_total = 0;
  logic                        truncated = 1'b0;

  psc_pkg::out_req_t expected_counts [$];
  int unsigned       error_count = 0;
  int unsigned       sent_items = 0;
  int unsigned       idle_pct = 0;
  int unsigned       stall_pct = 0;

  palindromic_substring_counter u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("FAILURE");
    $finish;
  end

  function automatic psc_pkg::out_req_t count_palindromes(
      input logic [psc_pkg::CHAR_W-1:0] c, input logic last);
    psc_pkg::out_req_t           res;
    logic [psc_pkg::MAX_LEN-1:0] next_flags;
    int unsigned                 hits;
    int unsigned                 i;
    logic                        inner;
    hits = 0;
    next_flags = '0;
    if (stored_len < psc_pkg::MAX_LEN) begin
      seen_chars[stored_len] = c;
      for (i = 0; i <= stored_len; i++) begin
        // spans of one or two characters need no inner palindrome
        inner = (stored_len - i <= 1) ? 1'b1 : end_flags[i+1];
        next_flags[i] = (seen_chars[i] == c) && inner;
        if (next_flags[i]) hits++;
      end
      end_flags = next_flags;
      stored_len++;
      pal_total = (pal_total + hits > psc_pkg::TOTAL_MAX) ? psc_pkg::TOTAL_MAX
                                                          : pal_total + hits;
    end else begin
      truncated = 1'b1;
    end
    res.pal_count = psc_pkg::CNT_W'(pal_total);
    res.done_res  = last;
    res.overflow  = truncated;
    if (last) begin
      end_flags = '0;
      stored_len = 0;
      pal_total = 0;
      truncated = 1'b0;
    end
    return res;
  endfunction

  function automatic void log_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("ERROR at %0t: %s", $time, msg);
  endfunction

  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    psc_pkg::out_req_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_counts.size() == 0) begin
        log_error($sformatf("unexpected result count=%0d done=%0b overflow=%0b",
                            out_data.pal_count, out_data.done_res, out_data.overflow));
      end else begin
        want = expected_counts.pop_front();
        if (out_data.pal_count !== want.pal_count || out_data.done_res !== want.done_res ||
            out_data.overflow !== want.overflow)
          log_error($sformatf("count exp %0d got %0d, done exp %0b got %0b, ovf exp %0b got %0b",
                              want.pal_count, out_data.pal_count, want.done_res,
                              out_data.done_res, want.overflow, out_data.overflow));
      end
    end
  end

  // Called at a rising edge; returns at the edge where the request is taken.
  task automatic send_char(input logic [psc_pkg::CHAR_W-1:0] c, input logic last);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{char_in: c, is_last: last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_counts.push_back(count_palindromes(c, last));
    sent_items++;
  endtask

  task automatic send_string(input logic [psc_pkg::CHAR_W-1:0] text [$]);
    int unsigned k;
    for (k = 0; k < text.size(); k++) send_char(text[k], k == text.size() - 1);
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_counts.size() != 0) @(posedge clk);
  endtask

  // Extreme bytes, tiny strings, odd and even palindromes.
  task automatic test_short_strings();
    send_string({8'h00});
    send_string({8'hFF});
    send_string({8'h55, 8'hAA, 8'h55});
    send_string({8'hAA, 8'hAA});
    send_string({8'h00, 8'hFF});
    send_string({8'h01, 8'h80, 8'h80, 8'h01});
    send_string({8'h7F, 8'hFE, 8'h7F, 8'hFE, 8'h7F});
    send_string({8'hFF, 8'h00, 8'hFF, 8'hFF});
  endtask

  // A string of MAX_LEN equal characters gives the largest possible total.
  task automatic test_full_length();
    logic [psc_pkg::CHAR_W-1:0] text [$];
    int unsigned                k;
    for (k = 0; k < psc_pkg::MAX_LEN; k++) text.push_back(8'h61);
    send_string(text);
  endtask

  // Characters past MAX_LEN are dropped; the last one may itself be dropped.
  task automatic test_truncation();
    logic [psc_pkg::CHAR_W-1:0] text [$];
    int unsigned                k;
    for (k = 0; k < psc_pkg::MAX_LEN + 3; k++) text.push_back((k % 3 == 0) ? 8'h3C : 8'hC3);
    send_string(text);
    text = {};
    for (k = 0; k < psc_pkg::MAX_LEN + 1; k++) text.push_back(8'($urandom_range(1, 2)));
    send_string(text);
  endtask

  // Sender stops mid-string until the block has drained, then finishes the string.
  task automatic test_pause_mid_string();
    send_char(8'h42, 1'b0);
    send_char(8'h24, 1'b0);
    wait_all_results();
    send_char(8'h24, 1'b0);
    send_char(8'h42, 1'b1);
    wait_all_results();
  endtask

  task automatic test_random_strings(input int unsigned idle, input int unsigned stall,
                                     input int unsigned goal);
    logic [psc_pkg::CHAR_W-1:0] text [$];
    logic [psc_pkg::CHAR_W-1:0] alphabet [3];
    int unsigned                start;
    int unsigned                len;
    int unsigned                kind;
    int unsigned                k;
    int                         m;
    wait_all_results();
    idle_pct = idle;
    stall_pct = stall;
    start = sent_items;
    while (sent_items - start < goal) begin
      text = {};
      kind = $urandom_range(99);
      for (k = 0; k < 3; k++) alphabet[k] = 8'($urandom);
      len = (kind < 97) ? $urandom_range(1, 14) : $urandom_range(50, psc_pkg::MAX_LEN + 6);
      if (kind < 30) begin
        for (k = 0; k < (len + 1) / 2; k++) text.push_back(alphabet[$urandom_range(2)]);
        for (m = int'(len / 2) - 1; m >= 0; m--) text.push_back(text[m]);
      end else if (kind >= 75 && kind < 90) begin
        for (k = 0; k < len; k++) text.push_back(8'($urandom));
      end else begin
        for (k = 0; k < len; k++) text.push_back(alphabet[$urandom_range(kind % 2 + 1)]);
      end
      send_string(text);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_short_strings();
    test_full_length();
    test_truncation();
    test_pause_mid_string();
    test_random_strings(0, 0, 107);
    test_random_strings(79, 0, 107);
    test_random_strings(0, 79, 107);
    test_random_strings(37, 37, 107);
    wait_all_results();
    repeat (8) @(posedge clk);
    if (error_count == 0 && expected_counts.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/psc_pkg.sv
hw/rtl/psc_cell.sv
hw/rtl/psc_popcount.sv
hw/rtl/palindromic_substring_counter.sv
test/tb_top.sv
